/* rtl/tcbb_pkg.sv */
// Package for the threaded-code branch backpatcher: command and status codes,
// payload structs for both channels and the job record passed front to back.
// No dependencies.
package tcbb_pkg;

  // Default sizes handed to the top-level parameters
  localparam int WORD_CAPACITY_DEF     = 4096;
  localparam int PATCH_STACK_DEPTH_DEF = 16;

  // Cell width of the target machine; cells are trimmed to it on output
  localparam int CELL_BITS = 32;

  // Fixed field widths of the channels
  localparam int CMD_W       = 4;
  localparam int ADDR_W      = 12;
  localparam int CELL_W      = 32;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int MAX_RESULTS = 3;
  localparam int SLOT_IDX_W  = $clog2(MAX_RESULTS);

  // Depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CELL_W-1:0] CELL_MASK =
    (CELL_BITS >= CELL_W) ? {CELL_W{1'b1}} : CELL_W'((64'd1 << CELL_BITS) - 64'd1);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CELL     = 4'd0;
  localparam logic [CMD_W-1:0] CMD_LITERAL  = 4'd1;
  localparam logic [CMD_W-1:0] CMD_IF       = 4'd2;
  localparam logic [CMD_W-1:0] CMD_ELSE     = 4'd3;
  localparam logic [CMD_W-1:0] CMD_ENDIF    = 4'd4;
  localparam logic [CMD_W-1:0] CMD_WHILE    = 4'd5;
  localparam logic [CMD_W-1:0] CMD_DO       = 4'd6;
  localparam logic [CMD_W-1:0] CMD_ENDWHILE = 4'd7;
  localparam logic [CMD_W-1:0] CMD_REPEAT   = 4'd8;
  localparam logic [CMD_W-1:0] CMD_FOREVER  = 4'd9;
  localparam logic [CMD_W-1:0] CMD_BUILD    = 4'd10;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OP_PUSH_LITERAL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OP_BRANCH_IF_FALSE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OP_BRANCH          = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OP_RETURN          = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CELL_W-1:0] cell_value;
  } in_item_t;

  typedef struct packed {
    logic                write_enable;
    logic [ADDR_W-1:0]   write_address;
    logic [CELL_W-1:0]   write_value;
    logic [STATUS_W-1:0] status;
    logic                word_done;
    logic                last;
  } out_item_t;

  // One cell write of a job
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] value;
  } slot_t;

  // All results of one command, ready to be played out
  typedef struct packed {
    logic [SLOT_IDX_W-1:0]           last_idx;
    logic [STATUS_W-1:0]             status;
    logic                            done;
    slot_t [MAX_RESULTS-1:0]         slots;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Trim a cell to the target cell width
  function automatic logic [CELL_W-1:0] cell_fit(input logic [CELL_W-1:0] v);
    return v & CELL_MASK;
  endfunction

endpackage

/* rtl/tcbb_front.sv */
// Front end of the backpatcher: accepts commands, checks them, keeps the write
// pointer, the patch stack and the opcode registers, and builds at most one job each.
// Depends on tcbb_pkg.
module tcbb_front import tcbb_pkg::*; #(
  parameter int WORD_CAPACITY     = WORD_CAPACITY_DEF,
  parameter int PATCH_STACK_DEPTH = PATCH_STACK_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CELL_W-1:0]    cfg_data,
  output logic                 push,
  output job_t                 push_job,
  input  q_status_t            q_status
);

  localparam int PTR_W = $clog2(WORD_CAPACITY + 1);
  localparam int POS_W = $clog2(WORD_CAPACITY);
  localparam int CNT_W = $clog2(PATCH_STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    STK_HOLD,
    STK_PUSH,
    STK_POP1,
    STK_POP2,
    STK_SET_TOP
  } stk_op_t;

  logic [CELL_W-1:0] op_push_literal;
  logic [CELL_W-1:0] op_branch_if_false;
  logic [CELL_W-1:0] op_branch;
  logic [CELL_W-1:0] op_return;

  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] wp_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic [POS_W-1:0] stk [PATCH_STACK_DEPTH];
  logic [POS_W-1:0] stk_down1 [PATCH_STACK_DEPTH];
  logic [POS_W-1:0] stk_up1 [PATCH_STACK_DEPTH];
  logic [POS_W-1:0] stk_up2 [PATCH_STACK_DEPTH];
  logic [POS_W-1:0] push_val;
  stk_op_t          stk_op;

  logic [1:0]       need_pop;
  logic [1:0]       need_cells;
  logic             need_push;
  logic             ignore;
  logic             underflow;
  logic             overflow;
  logic             full;
  logic             accept;
  logic             job_valid;
  logic [PTR_W-1:0] room;
  logic [PTR_W-1:0] wp_p1;
  logic [PTR_W-1:0] wp_p2;
  logic [POS_W-1:0] top;
  logic [POS_W-1:0] second;
  logic [ADDR_W-1:0] a_wp;
  logic [ADDR_W-1:0] a_wp1;
  logic [ADDR_W-1:0] a_top;

  function automatic slot_t mk_slot(input logic [ADDR_W-1:0] a, input logic [CELL_W-1:0] v);
    slot_t s;
    s.addr  = a;
    s.value = cell_fit(v);
    return s;
  endfunction

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  // Queue a job only for an accepted transaction
  assign push = accept && job_valid;

  // Decode what each command needs from the stack and the word buffer
  always_comb begin
    need_pop   = 2'd0;
    need_push  = 1'b0;
    need_cells = 2'd0;
    ignore     = 1'b0;
    unique case (in_data.command) inside
      CMD_CELL:               need_cells = 2'd1;
      CMD_LITERAL:            need_cells = 2'd2;
      CMD_IF, CMD_DO: begin
        need_cells = 2'd2;
        need_push  = 1'b1;
      end
      CMD_ELSE, CMD_FOREVER: begin
        need_cells = 2'd2;
        need_pop   = 2'd1;
      end
      CMD_ENDIF:              need_pop = 2'd1;
      CMD_WHILE, CMD_REPEAT: begin
        need_cells = 2'd1;
        need_push  = 1'b1;
      end
      CMD_ENDWHILE: begin
        need_cells = 2'd2;
        need_pop   = 2'd2;
      end
      CMD_BUILD:              need_cells = 2'd1;
      default:                ignore = 1'b1;
    endcase
  end

  // Check in priority order: underflow, overflow, buffer space
  assign room      = PTR_W'(WORD_CAPACITY) - wp;
  assign underflow = cnt < CNT_W'(need_pop);
  assign overflow  = need_push && (cnt == CNT_W'(PATCH_STACK_DEPTH));
  assign full      = room < PTR_W'(need_cells);

  assign wp_p1  = wp + PTR_W'(1);
  assign wp_p2  = wp + PTR_W'(2);
  assign top    = stk[0];
  assign second = stk[1];
  assign a_wp   = ADDR_W'(wp);
  assign a_wp1  = ADDR_W'(wp_p1);
  assign a_top  = ADDR_W'(top);

  // Build the job and the next pointer and stack state
  always_comb begin
    push_job  = '0;
    job_valid = 1'b0;
    wp_next   = wp;
    cnt_next  = cnt;
    stk_op    = STK_HOLD;
    push_val  = POS_W'(wp);
    if (ignore) begin
      job_valid = 1'b0;
    end else if (underflow) begin
      job_valid       = 1'b1;
      push_job.status = ST_UNDERFLOW;
    end else if (overflow) begin
      job_valid       = 1'b1;
      push_job.status = ST_OVERFLOW;
    end else if (full) begin
      job_valid       = 1'b1;
      push_job.status = ST_FULL;
    end else begin
      push_job.status = ST_OK;
      unique case (in_data.command) inside
        CMD_CELL: begin
          job_valid         = 1'b1;
          push_job.slots[0] = mk_slot(a_wp, in_data.cell_value);
          wp_next           = wp_p1;
        end
        CMD_LITERAL: begin
          job_valid         = 1'b1;
          push_job.last_idx = SLOT_IDX_W'(1);
          push_job.slots[0] = mk_slot(a_wp, op_push_literal);
          push_job.slots[1] = mk_slot(a_wp1, in_data.cell_value);
          wp_next           = wp_p2;
        end
        CMD_IF, CMD_DO: begin
          job_valid         = 1'b1;
          push_job.last_idx = SLOT_IDX_W'(1);
          push_job.slots[0] = mk_slot(a_wp, op_branch_if_false);
          push_job.slots[1] = mk_slot(a_wp1, '0);
          stk_op            = STK_PUSH;
          push_val          = POS_W'(wp_p1);
          cnt_next          = cnt + CNT_W'(1);
          wp_next           = wp_p2;
        end
        CMD_ELSE: begin
          job_valid         = 1'b1;
          push_job.last_idx = SLOT_IDX_W'(2);
          push_job.slots[0] = mk_slot(a_wp, op_branch);
          push_job.slots[1] = mk_slot(a_wp1, '0);
          push_job.slots[2] = mk_slot(a_top, CELL_W'(wp_p2));
          stk_op            = STK_SET_TOP;
          push_val          = POS_W'(wp_p1);
          wp_next           = wp_p2;
        end
        CMD_ENDIF: begin
          job_valid         = 1'b1;
          push_job.slots[0] = mk_slot(a_top, CELL_W'(wp));
          stk_op            = STK_POP1;
          cnt_next          = cnt - CNT_W'(1);
        end
        CMD_WHILE, CMD_REPEAT: begin
          stk_op   = STK_PUSH;
          push_val = POS_W'(wp);
          cnt_next = cnt + CNT_W'(1);
        end
        CMD_ENDWHILE: begin
          job_valid         = 1'b1;
          push_job.last_idx = SLOT_IDX_W'(2);
          push_job.slots[0] = mk_slot(a_wp, op_branch);
          push_job.slots[1] = mk_slot(a_wp1, CELL_W'(second));
          push_job.slots[2] = mk_slot(a_top, CELL_W'(wp_p2));
          stk_op            = STK_POP2;
          cnt_next          = cnt - CNT_W'(2);
          wp_next           = wp_p2;
        end
        CMD_FOREVER: begin
          job_valid         = 1'b1;
          push_job.last_idx = SLOT_IDX_W'(1);
          push_job.slots[0] = mk_slot(a_wp, op_branch);
          push_job.slots[1] = mk_slot(a_wp1, CELL_W'(top));
          stk_op            = STK_POP1;
          cnt_next          = cnt - CNT_W'(1);
          wp_next           = wp_p2;
        end
        CMD_BUILD: begin
          job_valid         = 1'b1;
          push_job.done     = 1'b1;
          push_job.slots[0] = mk_slot(a_wp, op_return);
          cnt_next          = '0;
          wp_next           = '0;
        end
        default: job_valid = 1'b0;
      endcase
    end
  end

  // Shifted views of the stack for push and pop
  for (genvar i = 0; i < PATCH_STACK_DEPTH; i++) begin : g_stk
    if (i == 0) begin : g_first
      assign stk_down1[i] = push_val;
    end else begin : g_rest
      assign stk_down1[i] = stk[i-1];
    end
    if (i + 1 < PATCH_STACK_DEPTH) begin : g_up1
      assign stk_up1[i] = stk[i+1];
    end else begin : g_up1_end
      assign stk_up1[i] = '0;
    end
    if (i + 2 < PATCH_STACK_DEPTH) begin : g_up2
      assign stk_up2[i] = stk[i+2];
    end else begin : g_up2_end
      assign stk_up2[i] = '0;
    end
  end

  // Shift the patch stack; top of stack sits at entry zero
  always_ff @(posedge clk) begin
    if (accept) begin
      case (stk_op)
        STK_PUSH:    stk <= stk_down1;
        STK_POP1:    stk <= stk_up1;
        STK_POP2:    stk <= stk_up2;
        STK_SET_TOP: stk[0] <= push_val;
        default:     stk <= stk;
      endcase
    end
  end

  // Advance pointer and count; take opcode register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      wp                 <= '0;
      cnt                <= '0;
      op_push_literal    <= CELL_W'(0);
      op_branch_if_false <= CELL_W'(1);
      op_branch          <= CELL_W'(2);
      op_return          <= CELL_W'(3);
    end else begin
      if (accept) begin
        wp  <= wp_next;
        cnt <= cnt_next;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_OP_PUSH_LITERAL:    op_push_literal    <= cfg_data;
          CFG_OP_BRANCH_IF_FALSE: op_branch_if_false <= cfg_data;
          CFG_OP_BRANCH:          op_branch          <= cfg_data;
          CFG_OP_RETURN:          op_return          <= cfg_data;
        endcase
      end
    end
  end

endmodule

/* rtl/tcbb_queue.sv */
// Short job queue between the front end and the write sequencer.
// Depends on tcbb_pkg.
module tcbb_queue import tcbb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  job_t      push_job,
  input  logic      pop,
  output job_t      head,
  output q_status_t status
);

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t          entries [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr;
  logic [QW-1:0] rd_ptr;
  logic [CW-1:0] count;

  function automatic logic [QW-1:0] wrap_inc(input logic [QW-1:0] p);
    return (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + QW'(1);
  endfunction

  assign head         = entries[rd_ptr];
  assign status.full  = count == CW'(QUEUE_DEPTH);
  assign status.empty = count == '0;

  // Store jobs
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

/* rtl/tcbb_back.sv */
// Write sequencer: plays out the cell writes of each queued job, one per cycle
// while the output is not stalled, through the output register. Depends on tcbb_pkg.
module tcbb_back import tcbb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  job_t      head,
  input  q_status_t q_status,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic [SLOT_IDX_W-1:0] idx;
  logic                  load;
  logic                  is_last;
  slot_t                 sl;
  out_item_t             res;

  assign load    = !q_status.empty && (!out_valid || !out_stall);
  assign is_last = idx == head.last_idx;
  assign pop     = load && is_last;
  assign sl      = head.slots[idx];

  // Form the current result of the head job
  always_comb begin
    res.write_enable  = head.status == ST_OK;
    res.write_address = sl.addr;
    res.write_value   = sl.value;
    res.status        = head.status;
    res.word_done     = head.done && is_last;
    res.last          = is_last;
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res;
    end
  end

  // Step through the job and hold the output while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      out_valid <= load || (out_valid && out_stall);
      if (load) begin
        idx <= is_last ? '0 : idx + SLOT_IDX_W'(1);
      end
    end
  end

endmodule

/* rtl/threaded_code_branch_backpatcher.sv */
// Threaded-code compiler for control flow: each command becomes up to three
// cell writes (appends at the write pointer and back-patches of earlier
// placeholders). A command that causes at most one write is taken every
// cycle while the job queue is not full; the write sequencer issues one cell
// write per cycle from its output register while the output is not stalled.
// A two-entry job queue sits between the command classifier and the
// sequencer, so commands keep being accepted while earlier writes drain.
// Stack and buffer errors give a single result and change no state. No
// clearing pass follows reset.
// Depends on tcbb_pkg, tcbb_front, tcbb_queue, tcbb_back.
module threaded_code_branch_backpatcher import tcbb_pkg::*; #(
  parameter int WORD_CAPACITY     = WORD_CAPACITY_DEF,
  parameter int PATCH_STACK_DEPTH = PATCH_STACK_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CELL_W-1:0]    cfg_data
);

  logic      q_push;
  job_t      q_push_job;
  logic      q_pop;
  job_t      q_head;
  q_status_t q_status;

  tcbb_front #(
    .WORD_CAPACITY     (WORD_CAPACITY),
    .PATCH_STACK_DEPTH (PATCH_STACK_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (q_push),
    .push_job  (q_push_job),
    .q_status  (q_status)
  );

  tcbb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_push_job),
    .pop      (q_pop),
    .head     (q_head),
    .status   (q_status)
  );

  tcbb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .q_status  (q_status),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Sequencer never retires a job from an empty queue
  assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_status.empty)
    else $error("job popped from empty queue");

  // Front never writes into a full queue
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_status.full || q_pop)
    else $error("job pushed into full queue");

  // Build completion is the last and a real write
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.word_done |-> out_data.last && out_data.write_enable)
    else $error("word done on a non-final or non-write result");

  // Error transactions are single and carry an error status
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.write_enable |-> out_data.last && (out_data.status != ST_OK))
    else $error("result without write is not a single error");

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// Testbench for threaded_code_branch_backpatcher: random and directed compile commands,
// an in-house prediction of every cell write, and field-by-field result checks.
// Depends on tcbb_pkg and the block's RTL.
module tb;
  import tcbb_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int PRINT_CAP = 50;

  // Predicts the cell writes of each compile command and checks them in order
  class backpatch_scoreboard;
    logic [CELL_W-1:0] op_literal, op_cond, op_jump, op_ret;
    logic [12:0] next_cell;
    logic [ADDR_W-1:0] patch_sites [PATCH_STACK_DEPTH_DEF];
    int open_sites;
    out_item_t cell_writes_due[$];
    int failures, commands_taken, ignored, results_checked, error_results, words_built;

    function new();
      op_literal = 0;
      op_cond = 1;
      op_jump = 2;
      op_ret = 3;
      next_cell = '0;
      open_sites = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CELL_W-1:0] val);
      case (idx)
        CFG_OP_PUSH_LITERAL:    op_literal = val;
        CFG_OP_BRANCH_IF_FALSE: op_cond = val;
        CFG_OP_BRANCH:          op_jump = val;
        CFG_OP_RETURN:          op_ret = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return cell_writes_due.size();
    endfunction

    function void add_write(logic [12:0] addr, logic [CELL_W-1:0] val, bit done);
      out_item_t w;
      w = '0;
      w.write_enable = 1'b1;
      w.write_address = addr[ADDR_W-1:0];
      w.write_value = val & CELL_MASK;
      w.status = ST_OK;
      w.word_done = done;
      cell_writes_due = {cell_writes_due, w};
    endfunction

    function void add_error(logic [STATUS_W-1:0] code);
      out_item_t w;
      w = '0;
      w.status = code;
      w.last = 1'b1;
      cell_writes_due = {cell_writes_due, w};
      error_results++;
    endfunction

    // Work out the writes caused by one accepted command and advance the state
    function void note_command(in_item_t item);
      int need_pop, need_push, need_cells, first;
      logic [12:0] wp;
      logic [ADDR_W-1:0] top, below;
      wp = next_cell;
      commands_taken++;
      if (item.command > CMD_BUILD) begin
        ignored++;
        return;
      end
      need_pop = 0;
      need_push = 0;
      need_cells = 0;
      case (item.command)
        CMD_CELL: need_cells = 1;
        CMD_LITERAL: need_cells = 2;
        CMD_IF, CMD_DO: begin
          need_cells = 2;
          need_push = 1;
        end
        CMD_ELSE, CMD_FOREVER: begin
          need_cells = 2;
          need_pop = 1;
        end
        CMD_ENDIF: need_pop = 1;
        CMD_WHILE, CMD_REPEAT: begin
          need_cells = 1;
          need_push = 1;
        end
        CMD_ENDWHILE: begin
          need_cells = 2;
          need_pop = 2;
        end
        default: need_cells = 1;
      endcase

      // Underflow wins over overflow, which wins over a full buffer
      if (open_sites < need_pop) begin
        add_error(ST_UNDERFLOW);
        return;
      end
      if (need_push != 0 && open_sites >= PATCH_STACK_DEPTH_DEF) begin
        add_error(ST_OVERFLOW);
        return;
      end
      if (WORD_CAPACITY_DEF - int'(wp) < need_cells) begin
        add_error(ST_FULL);
        return;
      end

      first = cell_writes_due.size();
      case (item.command)
        CMD_CELL: begin
          add_write(wp, item.cell_value, 1'b0);
          next_cell = wp + 13'd1;
        end
        CMD_LITERAL: begin
          add_write(wp, op_literal, 1'b0);
          add_write(wp + 13'd1, item.cell_value, 1'b0);
          next_cell = wp + 13'd2;
        end
        CMD_IF, CMD_DO: begin
          add_write(wp, op_cond, 1'b0);
          add_write(wp + 13'd1, '0, 1'b0);
          patch_sites[open_sites] = ADDR_W'(wp + 13'd1);
          open_sites++;
          next_cell = wp + 13'd2;
        end
        CMD_ELSE: begin
          top = patch_sites[open_sites - 1];
          add_write(wp, op_jump, 1'b0);
          add_write(wp + 13'd1, '0, 1'b0);
          add_write(13'(top), CELL_W'(wp) + 2, 1'b0);
          patch_sites[open_sites - 1] = ADDR_W'(wp + 13'd1);
          next_cell = wp + 13'd2;
        end
        CMD_ENDIF: begin
          open_sites--;
          top = patch_sites[open_sites];
          add_write(13'(top), CELL_W'(wp), 1'b0);
        end
        CMD_WHILE, CMD_REPEAT: begin
          patch_sites[open_sites] = ADDR_W'(wp);
          open_sites++;
        end
        CMD_ENDWHILE: begin
          top = patch_sites[open_sites - 1];
          below = patch_sites[open_sites - 2];
          open_sites -= 2;
          add_write(wp, op_jump, 1'b0);
          add_write(wp + 13'd1, CELL_W'(below), 1'b0);
          add_write(13'(top), CELL_W'(wp) + 2, 1'b0);
          next_cell = wp + 13'd2;
        end
        CMD_FOREVER: begin
          open_sites--;
          top = patch_sites[open_sites];
          add_write(wp, op_jump, 1'b0);
          add_write(wp + 13'd1, CELL_W'(top), 1'b0);
          next_cell = wp + 13'd2;
        end
        default: begin
          add_write(wp, op_ret, 1'b1);
          next_cell = '0;
          open_sites = 0;
          words_built++;
        end
      endcase
      if (cell_writes_due.size() > first)
        cell_writes_due[cell_writes_due.size() - 1].last = 1'b1;
    endfunction

    task report(string what, logic [CELL_W-1:0] want, logic [CELL_W-1:0] got);
      if (failures < PRINT_CAP)
        $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
      failures++;
    endtask

    // Compare one accepted result with the oldest expectation
    task check_result(out_item_t got);
      out_item_t want;
      results_checked++;
      if (cell_writes_due.size() == 0) begin
        report("result with nothing expected, address", '0, CELL_W'(got.write_address));
        return;
      end
      want = cell_writes_due.pop_front();
      if (got.write_enable !== want.write_enable)
        report("write_enable", CELL_W'(want.write_enable), CELL_W'(got.write_enable));
      if (got.write_address !== want.write_address)
        report("write_address", CELL_W'(want.write_address), CELL_W'(got.write_address));
      if (got.write_value !== want.write_value)
        report("write_value", want.write_value, got.write_value);
      if (got.status !== want.status)
        report("status", CELL_W'(want.status), CELL_W'(got.status));
      if (got.word_done !== want.word_done)
        report("word_done", CELL_W'(want.word_done), CELL_W'(got.word_done));
      if (got.last !== want.last)
        report("last", CELL_W'(want.last), CELL_W'(got.last));
    endtask

    task check_drained();
      while (cell_writes_due.size() > 0) begin
        report("missing result, address", CELL_W'(cell_writes_due[0].write_address), '0);
        void'(cell_writes_due.pop_front());
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_stall, out_valid, out_stall, cfg_write;
  in_item_t in_data;
  out_item_t out_data;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CELL_W-1:0] cfg_data;

  backpatch_scoreboard sb = new();
  in_item_t plan[$];
  bit no_idle = 1'b0;
  bit hold_request = 1'b0;
  int cycle_count = 0;

  threaded_code_branch_backpatcher DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stop a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Accept results with random stalls; hold off for a long stretch on request
  initial begin
    int stall_left, hold_left;
    stall_left = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        sb.check_result(out_data);
        stall_left = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (hold_request) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic void queue_value(logic [CMD_W-1:0] c, logic [CELL_W-1:0] v);
    in_item_t it;
    it.command = c;
    it.cell_value = v;
    plan = {plan, it};
  endfunction

  function automatic void queue_cmd(logic [CMD_W-1:0] c);
    queue_value(c, $urandom());
  endfunction

  // Well-formed control structures with random content
  function automatic void queue_body(int level);
    int n, kind;
    n = $urandom_range(1, 3);
    repeat (n) begin
      kind = (level >= 3) ? $urandom_range(0, 1) : $urandom_range(0, 6);
      case (kind)
        0: queue_cmd(CMD_CELL);
        1: queue_cmd(CMD_LITERAL);
        2: begin
          queue_cmd(CMD_IF);
          queue_body(level + 1);
          queue_cmd(CMD_ENDIF);
        end
        3: begin
          queue_cmd(CMD_IF);
          queue_body(level + 1);
          queue_cmd(CMD_ELSE);
          queue_body(level + 1);
          queue_cmd(CMD_ENDIF);
        end
        4: begin
          queue_cmd(CMD_WHILE);
          queue_body(level + 1);
          queue_cmd(CMD_DO);
          queue_body(level + 1);
          queue_cmd(CMD_ENDWHILE);
        end
        5: begin
          queue_cmd(CMD_REPEAT);
          queue_body(level + 1);
          queue_cmd(CMD_FOREVER);
        end
        default: queue_cmd(CMD_CELL);
      endcase
    end
  endfunction

  // Nest close to the stack depth, sometimes past it, then unwind
  function automatic void queue_deep_nest();
    int k;
    k = $urandom_range(13, 19);
    repeat (k) begin
      queue_cmd($urandom_range(0, 1) ? CMD_IF : CMD_REPEAT);
      if ($urandom_range(0, 2) == 0) queue_cmd(CMD_CELL);
    end
    repeat (k) queue_cmd($urandom_range(0, 3) == 0 ? CMD_FOREVER : CMD_ENDIF);
    queue_cmd(CMD_BUILD);
  endfunction

  function automatic void queue_random(int goal);
    int r;
    while (plan.size() < goal) begin
      r = $urandom_range(0, 9);
      if (r <= 5) begin
        queue_body(0);
        queue_cmd(CMD_BUILD);
      end else if (r == 6) begin
        queue_deep_nest();
      end else begin
        // noise: any code, unused ones included
        repeat ($urandom_range(3, 8)) queue_cmd(CMD_W'($urandom_range(0, 15)));
      end
    end
  endfunction

  function automatic void queue_directed();
    queue_value(CMD_CELL, 32'h0000_0000);
    queue_value(CMD_CELL, 32'hFFFF_FFFF);
    queue_value(CMD_LITERAL, 32'hA5A5_5A5A);
    queue_cmd(CMD_IF);
    queue_value(CMD_CELL, 32'h5555_AAAA);
    queue_cmd(CMD_ELSE);
    queue_cmd(CMD_CELL);
    queue_cmd(CMD_ENDIF);
    queue_cmd(CMD_WHILE);
    queue_cmd(CMD_CELL);
    queue_cmd(CMD_DO);
    queue_cmd(CMD_CELL);
    queue_cmd(CMD_ENDWHILE);
    queue_cmd(CMD_REPEAT);
    queue_cmd(CMD_CELL);
    queue_cmd(CMD_FOREVER);
    queue_cmd(CMD_BUILD);
    queue_cmd(CMD_ENDIF);
    queue_value(4'd11, 32'hFFFF_FFFF);
    queue_value(4'd15, 32'h0000_0000);
    queue_cmd(CMD_DO);
    queue_cmd(CMD_ENDWHILE);
    queue_cmd(CMD_ENDIF);
    queue_cmd(CMD_BUILD);
  endfunction

  // Fill the patch stack, probe overflow on every push, unwind, probe underflow
  function automatic void queue_stack_edges();
    queue_cmd(CMD_BUILD);
    repeat (PATCH_STACK_DEPTH_DEF) queue_cmd(CMD_WHILE);
    queue_cmd(CMD_WHILE);
    queue_cmd(CMD_REPEAT);
    queue_cmd(CMD_IF);
    queue_cmd(CMD_DO);
    queue_cmd(CMD_CELL);
    queue_cmd(CMD_ELSE);
    queue_cmd(CMD_ENDWHILE);
    repeat (PATCH_STACK_DEPTH_DEF - 3) queue_cmd(CMD_ENDIF);
    queue_cmd(CMD_FOREVER);
    queue_cmd(CMD_ENDIF);
    queue_cmd(CMD_ELSE);
    queue_cmd(CMD_FOREVER);
    queue_cmd(CMD_ENDWHILE);
    queue_cmd(CMD_BUILD);
  endfunction

  // Offer every planned command; note each transaction as it is accepted
  task automatic send_plan();
    in_item_t item;
    int gap;
    while (plan.size() > 0) begin
      item = plan.pop_front();
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data <= item;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      sb.note_command(item);
    end
    in_valid <= 1'b0;
  endtask

  // Drain all expected writes, then let the pipeline go quiet
  task automatic settle();
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CELL_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_opcodes(logic [CELL_W-1:0] lit, logic [CELL_W-1:0] cond,
                             logic [CELL_W-1:0] jump, logic [CELL_W-1:0] ret);
    write_reg(CFG_OP_PUSH_LITERAL, lit);
    write_reg(CFG_OP_BRANCH_IF_FALSE, cond);
    write_reg(CFG_OP_BRANCH, jump);
    write_reg(CFG_OP_RETURN, ret);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_write = 1'b0;
    cfg_index = CFG_OP_PUSH_LITERAL;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset opcodes, directed cases
    queue_directed();
    send_plan();
    settle();

    // all-zero opcodes
    set_opcodes('0, '0, '0, '0);
    queue_random(85);
    send_plan();
    settle();

    // all-ones opcodes, with the receiver holding off so the block backs up
    set_opcodes('1, '1, '1, '1);
    hold_request = 1'b1;
    queue_random(85);
    send_plan();
    settle();

    // random opcodes at full rate on both sides
    no_idle = 1'b1;
    set_opcodes($urandom(), $urandom(), $urandom(), $urandom());
    queue_random(85);
    send_plan();
    settle();
    no_idle = 1'b0;

    // fresh opcodes, then walk the patch stack from full to empty
    set_opcodes($urandom(), $urandom(), $urandom(), $urandom());
    queue_stack_edges();
    send_plan();
    settle();

    sb.check_drained();
    $display("Ran %0d commands (%0d unused codes): %0d results checked, %0d error results,",
             sb.commands_taken, sb.ignored, sb.results_checked, sb.error_results);
    $display("%0d words built over five opcode settings, stack taken to both limits",
             sb.words_built);
    if (sb.failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/tcbb_pkg.sv
rtl/tcbb_front.sv
rtl/tcbb_queue.sv
rtl/tcbb_back.sv
rtl/threaded_code_branch_backpatcher.sv
dv/tb.sv
